// ----- src/iorsp_pkg.sv -----
`default_nettype none

package iorsp_pkg;

    // Operation codes carried in the request mode field
    localparam logic [2:0] MODE_SET_NET   = 3'd0;
    localparam logic [2:0] MODE_CLR_NET   = 3'd1;
    localparam logic [2:0] MODE_SET_TOKEN = 3'd2;
    localparam logic [2:0] MODE_CLR_TOKEN = 3'd3;
    localparam logic [2:0] MODE_PICK      = 3'd4;
    localparam logic [2:0] MODE_QUERY_NET = 3'd5;

    // Pick result kinds
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_NET   = 2'd1;
    localparam logic [1:0] KIND_BLOCK = 2'd2;

    typedef struct packed {
        logic [2:0] mode;
        logic [3:0] net_index_in;
        logic [3:0] block_index_in;
        logic [4:0] token_index_in;
    } t_req;

    typedef struct packed {
        logic [1:0] found_kind;
        logic [3:0] found_net;
        logic [3:0] found_block;
        logic [4:0] found_token;
        logic       queue_is_ready;
        logic       bad_index;
    } t_rsp;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load_req;
        logic read_en;
        logic finish;
    } t_dp_cmd;

endpackage

`default_nettype wire

// ----- src/io_ready_set_priority_picker.sv -----
// A request is loaded, the token memory is read into a register in the read state,
// and the result is registered in the finish state, where the next request may be
// loaded; none is taken in the read state (one read port, write-back at finish).
// A finished result waits in the output register while the next request is taken.
// Reset (synchronous, active low) clears the network bitmap, device summary and the
// token memory valid bits at once; no clearing pass is needed.
`default_nettype none

module io_ready_set_priority_picker #(
    parameter int NET_QUEUES        = 16,
    parameter int BLOCK_DEVICES     = 16,
    parameter int TOKENS_PER_DEVICE = 32
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    output logic            o_stall,
    input  iorsp_pkg::t_req i_req,
    output logic            o_valid,
    input  wire             i_stall,
    output iorsp_pkg::t_rsp o_result
);
    import iorsp_pkg::*;

    t_dp_cmd cmd;

    iorsp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd)
    );

    iorsp_dp #(
        .NET_QUEUES        (NET_QUEUES),
        .BLOCK_DEVICES     (BLOCK_DEVICES),
        .TOKENS_PER_DEVICE (TOKENS_PER_DEVICE)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_req    (i_req),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

// ----- src/iorsp_ctrl.sv -----
`default_nettype none

module iorsp_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_stall,
    output logic               o_valid,
    input  wire                i_stall,
    output iorsp_pkg::t_dp_cmd o_cmd
);
    import iorsp_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   load_ok;

    // Result register is free or being drained this cycle
    assign load_ok = !r_out_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (load_ok) begin
                    n_state = i_valid ? ST_READ : ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_stall        = 1'b0;
                o_cmd.load_req = i_valid;
            end
            ST_READ: begin
                o_cmd.read_en = 1'b1;
            end
            ST_FINISH: begin
                if (load_ok) begin
                    o_stall        = 1'b0;
                    o_cmd.finish   = 1'b1;
                    o_cmd.load_req = i_valid;
                end
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

// ----- src/iorsp_dp.sv -----
`default_nettype none

module iorsp_dp #(
    parameter int NET_QUEUES        = 16,
    parameter int BLOCK_DEVICES     = 16,
    parameter int TOKENS_PER_DEVICE = 32
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  iorsp_pkg::t_dp_cmd i_cmd,
    input  iorsp_pkg::t_req    i_req,
    output iorsp_pkg::t_rsp    o_result
);
    import iorsp_pkg::*;

    localparam int NW = (NET_QUEUES > 1) ? $clog2(NET_QUEUES) : 1;
    localparam int DW = (BLOCK_DEVICES > 1) ? $clog2(BLOCK_DEVICES) : 1;
    localparam int TW = (TOKENS_PER_DEVICE > 1) ? $clog2(TOKENS_PER_DEVICE) : 1;

    t_req                         r_req;
    t_rsp                         r_result;
    t_rsp                         n_result;
    logic [NET_QUEUES-1:0]        r_net_bits;
    logic [NET_QUEUES-1:0]        n_net_bits;
    logic [BLOCK_DEVICES-1:0]     r_dev_nonzero;
    logic [BLOCK_DEVICES-1:0]     r_entry_valid;
    logic [TOKENS_PER_DEVICE-1:0] r_mem [BLOCK_DEVICES];
    logic [TOKENS_PER_DEVICE-1:0] r_rd_data;
    logic                         r_rd_valid;
    logic [DW-1:0]                r_pick_dev;
    logic                         r_pick_any;

    logic                         is_net_op;
    logic                         is_tok_op;
    logic                         net_bad;
    logic                         tok_bad;
    logic                         bad;
    logic [NW-1:0]                net_addr;
    logic [DW-1:0]                blk_addr;
    logic [TW-1:0]                tok_addr;
    logic [DW-1:0]                rd_addr;
    logic [DW-1:0]                dev_enc;
    logic [NW-1:0]                net_enc;
    logic [TW-1:0]                tok_enc;
    logic [TOKENS_PER_DEVICE-1:0] word;
    logic [TOKENS_PER_DEVICE-1:0] tok_mask;
    logic [TOKENS_PER_DEVICE-1:0] new_word;
    logic                         tok_write;

    assign is_net_op = (r_req.mode == MODE_SET_NET) || (r_req.mode == MODE_CLR_NET)
                    || (r_req.mode == MODE_QUERY_NET);
    assign is_tok_op = (r_req.mode == MODE_SET_TOKEN) || (r_req.mode == MODE_CLR_TOKEN);

    assign net_bad = 32'(r_req.net_index_in) >= NET_QUEUES;
    assign tok_bad = (32'(r_req.block_index_in) >= BLOCK_DEVICES)
                  || (32'(r_req.token_index_in) >= TOKENS_PER_DEVICE);
    assign bad     = (is_net_op && net_bad) || (is_tok_op && tok_bad);

    assign net_addr = NW'(r_req.net_index_in);
    assign blk_addr = DW'(r_req.block_index_in);
    assign tok_addr = TW'(r_req.token_index_in);

    // Lowest set bit searches
    always_comb begin
        dev_enc = '0;
        for (int i = BLOCK_DEVICES - 1; i >= 0; i--) begin
            if (r_dev_nonzero[i]) begin
                dev_enc = DW'(i);
            end
        end
    end

    always_comb begin
        net_enc = '0;
        for (int i = NET_QUEUES - 1; i >= 0; i--) begin
            if (r_net_bits[i]) begin
                net_enc = NW'(i);
            end
        end
    end

    always_comb begin
        tok_enc = '0;
        for (int i = TOKENS_PER_DEVICE - 1; i >= 0; i--) begin
            if (word[i]) begin
                tok_enc = TW'(i);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < TOKENS_PER_DEVICE; i++) begin
            tok_mask[i] = (tok_addr == TW'(i));
        end
    end

    // An entry never written reads as zero
    assign word      = r_rd_valid ? r_rd_data : '0;
    assign new_word  = (r_req.mode == MODE_SET_TOKEN) ? (word | tok_mask) : (word & ~tok_mask);
    assign tok_write = i_cmd.finish && is_tok_op && !tok_bad;
    assign rd_addr   = is_tok_op ? blk_addr : dev_enc;

    always_comb begin
        n_net_bits = r_net_bits;
        n_result   = '0;
        n_result.bad_index = bad;
        priority case (1'b1)
            bad: begin
                n_result.bad_index = 1'b1;
            end
            (r_req.mode == MODE_SET_NET): begin
                n_net_bits[net_addr] = 1'b1;
            end
            (r_req.mode == MODE_CLR_NET): begin
                n_net_bits[net_addr] = 1'b0;
            end
            (r_req.mode == MODE_QUERY_NET): begin
                n_result.queue_is_ready = r_net_bits[net_addr];
            end
            (r_req.mode == MODE_PICK): begin
                if (|r_net_bits) begin
                    n_result.found_kind = KIND_NET;
                    n_result.found_net  = 4'(net_enc);
                end else if (r_pick_any) begin
                    n_result.found_kind  = KIND_BLOCK;
                    n_result.found_block = 4'(r_pick_dev);
                    n_result.found_token = 5'(tok_enc);
                end else begin
                    n_result.found_kind = KIND_NONE;
                end
            end
            default: begin
                n_result = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_req;
        end
        if (i_cmd.read_en) begin
            r_rd_data  <= r_mem[rd_addr];
            r_rd_valid <= r_entry_valid[rd_addr];
            r_pick_dev <= dev_enc;
            r_pick_any <= |r_dev_nonzero;
        end
        if (tok_write) begin
            r_mem[blk_addr] <= new_word;
        end
        if (i_cmd.finish) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_net_bits    <= '0;
            r_dev_nonzero <= '0;
            r_entry_valid <= '0;
        end else if (i_cmd.finish) begin
            r_net_bits <= n_net_bits;
            if (tok_write) begin
                r_entry_valid[blk_addr] <= 1'b1;
                r_dev_nonzero[blk_addr] <= |new_word;
            end
        end
    end

    assign o_result = r_result;

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import iorsp_pkg::*;

    localparam int NET_QUEUES        = 16;
    localparam int BLOCK_DEVICES     = 16;
    localparam int TOKENS_PER_DEVICE = 32;

    // Mode codes the block leaves unused
    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;

    localparam int HOLD_OFF_CYCLES = 150;
    localparam int DRAIN_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int MAX_REPORTS     = 100;

    class ready_set_predictor;
        bit [NET_QUEUES-1:0]        net_bits;
        bit [TOKENS_PER_DEVICE-1:0] token_bits [BLOCK_DEVICES];
        bit [BLOCK_DEVICES-1:0]     device_bits;
        t_rsp                       awaited_rsp [$];
        int unsigned                failures;

        function int lowest_set(bit [63:0] word, int limit);
            for (int i = 0; i < limit; i++) begin
                if (word[i]) return i;
            end
            return limit;
        endfunction

        function void note_request(t_req r);
            t_rsp want;
            int   n;
            int   d;
            int   t;
            want = '0;
            case (r.mode)
                MODE_SET_NET, MODE_CLR_NET, MODE_QUERY_NET: begin
                    if (r.net_index_in >= NET_QUEUES) begin
                        want.bad_index = 1'b1;
                    end else if (r.mode == MODE_SET_NET) begin
                        net_bits[r.net_index_in] = 1'b1;
                    end else if (r.mode == MODE_CLR_NET) begin
                        net_bits[r.net_index_in] = 1'b0;
                    end else begin
                        want.queue_is_ready = net_bits[r.net_index_in];
                    end
                end
                MODE_SET_TOKEN, MODE_CLR_TOKEN: begin
                    if (r.block_index_in >= BLOCK_DEVICES ||
                        r.token_index_in >= TOKENS_PER_DEVICE) begin
                        want.bad_index = 1'b1;
                    end else begin
                        token_bits[r.block_index_in][r.token_index_in] =
                            (r.mode == MODE_SET_TOKEN);
                        device_bits[r.block_index_in] = |token_bits[r.block_index_in];
                    end
                end
                MODE_PICK: begin
                    n = lowest_set(64'(net_bits), NET_QUEUES);
                    if (n < NET_QUEUES) begin
                        want.found_kind = KIND_NET;
                        want.found_net  = 4'(n);
                    end else begin
                        d = lowest_set(64'(device_bits), BLOCK_DEVICES);
                        if (d < BLOCK_DEVICES) begin
                            t = lowest_set(64'(token_bits[d]), TOKENS_PER_DEVICE);
                            if (t < TOKENS_PER_DEVICE) begin
                                want.found_kind  = KIND_BLOCK;
                                want.found_block = 4'(d);
                                want.found_token = 5'(t);
                            end
                        end
                    end
                end
                default: ;
            endcase
            awaited_rsp.push_back(want);
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("%0t: %s mismatch, expected %0d, actual %0d",
                             $time, name, want, got);
            end
        endfunction

        function void check_result(t_rsp got);
            t_rsp want;
            if (awaited_rsp.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, got);
                return;
            end
            want = awaited_rsp.pop_front();
            check_field("found_kind", want.found_kind, got.found_kind);
            check_field("found_net", want.found_net, got.found_net);
            check_field("found_block", want.found_block, got.found_block);
            check_field("found_token", want.found_token, got.found_token);
            check_field("queue_is_ready", want.queue_is_ready, got.queue_is_ready);
            check_field("bad_index", want.bad_index, got.bad_index);
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    t_req i_req   = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    t_rsp o_result;

    bit sender_idles   = 1'b1;
    bit receiver_idles = 1'b1;
    bit hold_off_req   = 1'b0;

    int unsigned quiet_cycles = 0;

    ready_set_predictor ready_set = new();

    io_ready_set_priority_picker i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_req    (i_req),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_req make_request(logic [2:0] m, int n, int b, int t);
        t_req r;
        r.mode           = m;
        r.net_index_in   = 4'(n);
        r.block_index_in = 4'(b);
        r.token_index_in = 5'(t);
        return r;
    endfunction

    function automatic t_req random_request();
        t_req r;
        int   roll;
        int   d;
        r    = t_req'(16'($urandom));
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            r.mode = MODE_SET_NET;
        end else if (roll < 22) begin
            r.mode = MODE_CLR_NET;
            // mostly retire a queue that is ready, so block tokens get picked too
            if (ready_set.net_bits != 0 && $urandom_range(0, 99) < 70)
                r.net_index_in = 4'(ready_set.lowest_set(64'(ready_set.net_bits),
                                                         NET_QUEUES));
        end else if (roll < 42) begin
            r.mode = MODE_SET_TOKEN;
        end else if (roll < 55) begin
            r.mode = MODE_CLR_TOKEN;
            if (ready_set.device_bits != 0 && $urandom_range(0, 99) < 70) begin
                d = ready_set.lowest_set(64'(ready_set.device_bits), BLOCK_DEVICES);
                r.block_index_in = 4'(d);
                r.token_index_in = 5'(ready_set.lowest_set(
                    64'(ready_set.token_bits[d]), TOKENS_PER_DEVICE));
            end
        end else if (roll < 82) begin
            r.mode = MODE_PICK;
        end else if (roll < 93) begin
            r.mode = MODE_QUERY_NET;
        end else begin
            r.mode = ($urandom_range(0, 1) != 0) ? MODE_SPARE_7 : MODE_SPARE_6;
        end
        return r;
    endfunction

    // Call at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input t_req r);
        while (sender_idles && $urandom_range(0, 99) < 35) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (o_stall);
        ready_set.note_request(r);
        @(negedge i_clk);
    endtask

    task automatic wait_results_drained();
        i_valid <= 1'b0;
        while (ready_set.awaited_rsp.size() != 0) @(negedge i_clk);
    endtask

    // Receiver: random stall, or one long hold-off when requested
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                i_stall <= receiver_idles && ($urandom_range(0, 99) < 35);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            ready_set.check_result(o_result);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty picks, extremes, priority order, spare modes
        send_request(make_request(MODE_PICK, 0, 0, 0));
        send_request(make_request(MODE_QUERY_NET, 0, 15, 31));
        send_request(make_request(MODE_SET_NET, 15, 0, 0));
        send_request(make_request(MODE_QUERY_NET, 15, 0, 0));
        send_request(make_request(MODE_QUERY_NET, 0, 0, 0));
        send_request(make_request(MODE_PICK, 15, 15, 31));
        send_request(make_request(MODE_SET_NET, 0, 15, 31));
        send_request(make_request(MODE_PICK, 0, 0, 0));
        send_request(make_request(MODE_CLR_NET, 0, 0, 0));
        send_request(make_request(MODE_CLR_NET, 15, 0, 0));
        send_request(make_request(MODE_PICK, 0, 0, 0));
        send_request(make_request(MODE_SET_TOKEN, 15, 15, 31));
        send_request(make_request(MODE_PICK, 0, 0, 0));
        send_request(make_request(MODE_SET_TOKEN, 0, 0, 31));
        send_request(make_request(MODE_SET_TOKEN, 0, 0, 0));
        send_request(make_request(MODE_PICK, 0, 0, 0));
        send_request(make_request(MODE_CLR_TOKEN, 0, 0, 0));
        send_request(make_request(MODE_PICK, 0, 0, 0));
        send_request(make_request(MODE_CLR_TOKEN, 0, 0, 31));
        send_request(make_request(MODE_CLR_TOKEN, 0, 15, 31));
        send_request(make_request(MODE_CLR_TOKEN, 0, 7, 5));
        send_request(make_request(MODE_PICK, 0, 0, 0));
        send_request(make_request(MODE_SPARE_6, 15, 15, 31));
        send_request(make_request(MODE_SPARE_7, 15, 15, 31));
        send_request(make_request(MODE_SET_NET, 9, 15, 31));
        send_request(make_request(MODE_SET_TOKEN, 15, 3, 0));
        send_request(make_request(MODE_PICK, 0, 0, 0));

        for (int k = 0; k < 600; k++) send_request(random_request());

        // stretch with no idling on either side
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        for (int k = 0; k < 300; k++) send_request(random_request());
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;

        // hold off the receiver and keep offering requests so that the block backs up
        hold_off_req = 1'b1;
        for (int k = 0; k < 100; k++) send_request(random_request());

        wait_results_drained();
        for (int k = 0; k < 400; k++) send_request(random_request());

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (ready_set.failures == 0 && ready_set.awaited_rsp.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
